// ===== rtl/tfr_pkg.sv =====
// ----------------------------------------------------------------------------
// tfr_pkg
// Types, constants and the CRC helper shared by the telemetry frame receiver.
// ----------------------------------------------------------------------------
package tfr_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_PAY  = 3'd2,
      PH_CRCH = 3'd3,
      PH_CRCL = 3'd4,
      PH_END  = 3'd5
   } tfr_phase_type;

   // input operations
   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_POLL = 2'd1;
   localparam logic [1:0] OP_STOP = 2'd2;

   // event kinds
   localparam logic [3:0] KIND_ALIVE   = 4'd0;
   localparam logic [3:0] KIND_DUTY    = 4'd1;
   localparam logic [3:0] KIND_RPM     = 4'd2;
   localparam logic [3:0] KIND_VOLTAGE = 4'd3;
   localparam logic [3:0] KIND_BATTERY = 4'd4;
   localparam logic [3:0] KIND_BAD_LEN = 4'd5;
   localparam logic [3:0] KIND_BOUNDS  = 4'd6;
   localparam logic [3:0] KIND_FAULT   = 4'd7;
   localparam logic [3:0] KIND_TIMEOUT = 4'd8;

   // config register indexes
   localparam logic [1:0] CSR_RPM_LIMIT = 2'd0;
   localparam logic [1:0] CSR_MAX_POLLS = 2'd1;
   localparam logic [1:0] CSR_VOLT_EN   = 2'd2;

   // framing constants
   localparam logic [7:0]  SOF_CODE    = 8'h02;
   localparam logic [7:0]  EOF_CODE    = 8'h03;
   localparam logic [7:0]  CMD_VALUES  = 8'd51;
   localparam logic [31:0] VALUE_MASK  = 32'h0001_01b0;
   localparam int          VALUE_LEN   = 16;
   localparam int          NUM_SLOTS   = 6;

   typedef struct packed {
      logic [14:0] rpm_limit;
      logic [2:0]  max_polls;
      logic        volt_en;
   } tfr_cfg_type;

   // fixed event slots: 0 alive/timeout, 1 duty or check error, 2 rpm,
   // 3 voltage, 4 battery, 5 fault
   typedef struct packed {
      logic [NUM_SLOTS-1:0]        valid;
      logic [NUM_SLOTS-1:0][3:0]   kind;
      logic [NUM_SLOTS-1:0][15:0]  value;
      logic                        busy;
   } tfr_events_type;

   // CRC16-CCITT, poly 0x1021, one byte folded msb first
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== rtl/tfr_parser.sv =====
// ----------------------------------------------------------------------------
// tfr_parser
// Frame parser, value checker and poll tracker; one word per cycle.
// ----------------------------------------------------------------------------
module tfr_parser #(
   parameter int MAX_FRAME_PAYLOAD = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  logic [1:0]             operation,
   input  logic [7:0]             rx_byte,
   input  tfr_pkg::tfr_cfg_type   cfg,
   output tfr_pkg::tfr_events_type events
);
   import tfr_pkg::*;

   localparam int LW = $clog2(MAX_FRAME_PAYLOAD + 1);

   tfr_phase_type phase_ff, phase_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [15:0]   crc_ff, crc_in;
   logic [15:0]   rcrc_ff, rcrc_in;
   logic          alive_ff, alive_in;
   logic [2:0]    outst_ff, outst_in;
   logic [15:0]   duty_ff, duty_in;
   logic [15:0]   speed_ff, speed_in;
   logic [15:0]   volt_ff, volt_in;
   logic [15:0]   batt_ff, batt_in;
   logic [7:0]    fault_ff, fault_in;
   logic [7:0]    buf_ff [VALUE_LEN];
   logic          buf_we;

   // decoded payload fields
   logic [31:0]        mask_w;
   logic signed [15:0] duty_w, batt_w;
   logic signed [31:0] rpm_w, lim_w;
   logic [15:0]        volt_w;
   logic               ok_w;

   assign mask_w = {buf_ff[1], buf_ff[2], buf_ff[3], buf_ff[4]};
   assign duty_w = {buf_ff[5], buf_ff[6]};
   assign rpm_w  = {buf_ff[7], buf_ff[8], buf_ff[9], buf_ff[10]};
   assign volt_w = {buf_ff[11], buf_ff[12]};
   assign batt_w = {buf_ff[13], buf_ff[14]};
   assign lim_w  = $signed({17'd0, cfg.rpm_limit});
   assign ok_w   = (mask_w == VALUE_MASK) && (duty_w >= -16'sd1000) &&
                   (duty_w <= 16'sd1000) && (rpm_w >= -lim_w) && (rpm_w <= lim_w) &&
                   (batt_w >= 16'sd0) && (batt_w <= 16'sd1000);

   // next state and events
   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      rcrc_in  = rcrc_ff;
      alive_in = alive_ff;
      outst_in = outst_ff;
      duty_in  = duty_ff;
      speed_in = speed_ff;
      volt_in  = volt_ff;
      batt_in  = batt_ff;
      fault_in = fault_ff;
      buf_we   = 1'b0;
      events   = '0;
      if (item_valid) begin
         unique case (operation)
            OP_BYTE: begin
               outst_in = '0;
               unique case (phase_ff)
                  PH_HUNT: if (rx_byte == SOF_CODE) phase_in = PH_LEN;
                  PH_LEN: begin
                     if ({1'b0, rx_byte} > 9'(MAX_FRAME_PAYLOAD)) begin
                        phase_in = PH_HUNT;
                     end else begin
                        len_in   = LW'(rx_byte);
                        pos_in   = '0;
                        crc_in   = '0;
                        phase_in = (rx_byte == 8'd0) ? PH_CRCH : PH_PAY;
                     end
                  end
                  PH_PAY: begin
                     buf_we = ({1'b0, pos_ff} < (LW+1)'(VALUE_LEN));
                     crc_in = crc_fold(crc_ff, rx_byte);
                     pos_in = pos_ff + 1'b1;
                     if ({1'b0, pos_ff} + 1'b1 >= {1'b0, len_ff}) phase_in = PH_CRCH;
                  end
                  PH_CRCH: begin
                     rcrc_in  = {rx_byte, 8'h00};
                     phase_in = PH_CRCL;
                  end
                  PH_CRCL: begin
                     rcrc_in  = {rcrc_ff[15:8], rx_byte};
                     phase_in = PH_END;
                  end
                  default: begin
                     phase_in = PH_HUNT;
                     if (rx_byte == EOF_CODE && crc_ff == rcrc_ff) begin
                        if (!alive_ff) begin
                           events.valid[0] = 1'b1;
                           events.kind[0]  = KIND_ALIVE;
                        end
                        alive_in = 1'b1;
                        if (len_ff != '0 && buf_ff[0] == CMD_VALUES) begin
                           if (len_ff != LW'(VALUE_LEN)) begin
                              events.valid[1] = 1'b1;
                              events.kind[1]  = KIND_BAD_LEN;
                           end else if (!ok_w) begin
                              events.valid[1] = 1'b1;
                              events.kind[1]  = KIND_BOUNDS;
                           end else begin
                              // changed values only
                              events.kind  = {KIND_FAULT, KIND_BATTERY, KIND_VOLTAGE,
                                              KIND_RPM, KIND_DUTY, KIND_ALIVE};
                              events.value[1] = duty_w;
                              events.value[2] = rpm_w[15:0];
                              events.value[3] = volt_w;
                              events.value[4] = batt_w;
                              events.value[5] = {8'd0, buf_ff[15]};
                              events.valid[1] = (duty_w != duty_ff);
                              events.valid[2] = (rpm_w[15:0] != speed_ff);
                              events.valid[3] = cfg.volt_en && (volt_w != volt_ff);
                              events.valid[4] = (batt_w != batt_ff);
                              events.valid[5] = (buf_ff[15] != fault_ff);
                              events.valid[0] = !alive_ff;
                              duty_in  = duty_w;
                              speed_in = rpm_w[15:0];
                              if (cfg.volt_en) volt_in = volt_w;
                              batt_in  = batt_w;
                              fault_in = buf_ff[15];
                           end
                        end
                     end
                  end
               endcase
            end
            OP_POLL: begin
               if (alive_ff) begin
                  if (outst_ff >= cfg.max_polls) begin
                     events.valid[0] = 1'b1;
                     events.kind[0]  = KIND_TIMEOUT;
                     alive_in = 1'b0;
                     outst_in = '0;
                  end else begin
                     outst_in = outst_ff + 1'b1;
                  end
               end
            end
            OP_STOP: alive_in = 1'b0;
            default: ;
         endcase
      end
      events.busy = alive_in && (outst_in != '0);
   end

   // control and value state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         len_ff   <= '0;
         pos_ff   <= '0;
         crc_ff   <= '0;
         rcrc_ff  <= '0;
         alive_ff <= 1'b0;
         outst_ff <= '0;
         duty_ff  <= '0;
         speed_ff <= '0;
         volt_ff  <= '0;
         batt_ff  <= '0;
         fault_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         rcrc_ff  <= rcrc_in;
         alive_ff <= alive_in;
         outst_ff <= outst_in;
         duty_ff  <= duty_in;
         speed_ff <= speed_in;
         volt_ff  <= volt_in;
         batt_ff  <= batt_in;
         fault_ff <= fault_in;
      end
   end

   // payload bytes that the value check reads
   always_ff @(posedge clock) begin
      if (buf_we) buf_ff[pos_ff[3:0]] <= rx_byte;
   end

endmodule

// ===== rtl/tfr_event_queue.sv =====
// ----------------------------------------------------------------------------
// tfr_event_queue
// Holds the events of one word and hands them out in slot order, one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module tfr_event_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  tfr_pkg::tfr_events_type events,
   output logic                    can_load,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3:0]              rsp_event_kind,
   output logic signed [15:0]      rsp_event_value,
   output logic                    rsp_busy_res,
   output logic                    rsp_last
);
   import tfr_pkg::*;

   logic [NUM_SLOTS-1:0]       valid_ff, valid_in;
   logic [NUM_SLOTS-1:0][3:0]  kind_ff;
   logic [NUM_SLOTS-1:0][15:0] value_ff;
   logic                       busy_ff;
   logic [NUM_SLOTS-1:0]       sel;
   logic [NUM_SLOTS-1:0]       rest;

   // lowest pending slot goes out first
   always_comb begin
      sel = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i]) sel = NUM_SLOTS'(1) << i;
      end
      rsp_event_kind  = '0;
      rsp_event_value = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (sel[i]) begin
            rsp_event_kind  = kind_ff[i];
            rsp_event_value = value_ff[i];
         end
      end
   end

   assign rsp_valid    = valid_ff != '0;
   assign rsp_last     = (valid_ff & ~sel) == '0;
   assign rsp_busy_res = busy_ff;
   assign rest         = (rsp_valid && rsp_ready) ? (valid_ff & ~sel) : valid_ff;
   assign can_load     = rest == '0;
   assign valid_in     = load ? events.valid : rest;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= events.kind;
         value_ff <= events.value;
         busy_ff  <= events.busy;
      end
   end

endmodule

// ===== rtl/telemetry_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// telemetry_frame_receiver
// Framed telemetry parser with CRC16-CCITT check, value events and poll timeout.
// ----------------------------------------------------------------------------
// The first event of a word is registered and valid in the cycle after the word is accepted.
// One word per cycle while no events are pending; a word with several events holds
//   req_ready low while the event register drains, one event a cycle while rsp_ready is high.
// Reset: synchronous, clears parser, alive, poll count, stored values and
//   config to 25000 / 5 / 1; payload bytes are undefined until received.
module telemetry_frame_receiver #(
   parameter int MAX_FRAME_PAYLOAD = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_event_kind,
   output logic signed [15:0] rsp_event_value,
   output logic               rsp_busy_res,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_write_data
);
   import tfr_pkg::*;

   tfr_cfg_type    cfg_ff;
   tfr_events_type events;
   logic           accept;

   assign accept = req_valid && req_ready;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rpm_limit <= 15'd25000;
         cfg_ff.max_polls <= 3'd5;
         cfg_ff.volt_en   <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RPM_LIMIT: cfg_ff.rpm_limit <= csr_write_data;
            CSR_MAX_POLLS: cfg_ff.max_polls <= csr_write_data[2:0];
            CSR_VOLT_EN:   cfg_ff.volt_en   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   tfr_parser #(.MAX_FRAME_PAYLOAD(MAX_FRAME_PAYLOAD)) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .operation  (req_operation),
      .rx_byte    (req_rx_byte),
      .cfg        (cfg_ff),
      .events     (events)
   );

   tfr_event_queue u_queue (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .events          (events),
      .can_load        (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_value (rsp_event_value),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_last        (rsp_last)
   );

`ifndef ASSERT_OFF
   // a new word only enters as the final pending event leaves
   a_accept_on_last: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_valid) |-> (rsp_last && rsp_ready))
      else $error("word accepted while events still pending");

   // events of one word follow each other with the same busy flag
   a_busy_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (rsp_valid && $stable(rsp_busy_res)))
      else $error("event train broken or busy changed");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && req_ready))
      else $error("events pending after reset");
`endif

endmodule
